// ===== hdl/mshw_pkg.sv =====
// shared types, constants and field offsets of the heartbeat watchdog
// no dependencies; imported by every module of the block and by the checker
`default_nettype none

package mshw_pkg;

  // field widths of one request and one result
  localparam int unsigned ReqW      = 2;
  localparam int unsigned SvcW      = 8;
  localparam int unsigned TimeW     = 64;
  localparam int unsigned MaskW     = 8;
  localparam int unsigned DeadlineW = 32;

  // largest service count the masks can carry, and the default
  localparam int unsigned MaxServices     = 8;
  localparam int unsigned ServiceCountDef = 8;

  // deadline after reset, in ms
  localparam logic [DeadlineW-1:0] DeadlineRst = 32'd1000;

  // request queue between front and back, power of two
  localparam int unsigned QueueDepth = 2;

  // input tdata: service_index then now_ms
  localparam int unsigned InSvcLo   = 0;
  localparam int unsigned InTimeLo  = InSvcLo + SvcW;
  localparam int unsigned InDataW   = ((InTimeLo + TimeW + 7) / 8) * 8;

  // output tdata: stale_mask, fault_flag, received_mask, heartbeat_taken, evaluation_time
  localparam int unsigned OutStaleLo  = 0;
  localparam int unsigned OutFaultBit = OutStaleLo + MaskW;
  localparam int unsigned OutRecvLo   = OutFaultBit + 1;
  localparam int unsigned OutTakenBit = OutRecvLo + MaskW;
  localparam int unsigned OutTimeLo   = OutTakenBit + 1;
  localparam int unsigned OutUsedW    = OutTimeLo + TimeW;
  localparam int unsigned OutDataW    = ((OutUsedW + 7) / 8) * 8;

  // request codes
  typedef enum logic [ReqW-1:0] {
    REQ_INIT = 2'd0,
    REQ_BEAT = 2'd1,
    REQ_EVAL = 2'd2,
    REQ_NONE = 2'd3
  } req_e;

  // one classified request as it waits in the queue
  typedef struct packed {
    req_e             kind;
    logic             svc_ok;
    logic [SvcW-1:0]  svc;
    logic [TimeW-1:0] now;
  } req_t;

  // one result item
  typedef struct packed {
    logic [TimeW-1:0] eval_time;
    logic             taken;
    logic [MaskW-1:0] recv;
    logic             fault;
    logic [MaskW-1:0] stale;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/multi_service_heartbeat_watchdog_core.sv =====
// top level of the multi-service heartbeat watchdog: ports, deadline register,
// front end and back end; depends on mshw_pkg, mshw_front, mshw_back
//
//   channel   dir  handshake                   payload
//   s_axis    in   s_axis_tvalid/tready        tuser req_type, tdata request fields
//   m_axis    out  m_axis_tvalid/tready        tdata result fields
//   cfg       in   cfg_we_i                    cfg_wdata_i deadline_limit
//
// the back end serves init, heartbeat and unused codes in idle; evaluate runs one stamp
// compare per cycle on the shared 65-bit subtractor, the last held until output frees.
// a two-entry request queue sits in front of the back end, so input is taken
// while the back end works or while a result waits in the output register.
// reset clears all stamps, marks and the evaluation time and sets the deadline to 1000;
// there is no clearing pass.
`default_nettype none

module multi_service_heartbeat_watchdog_core
  import mshw_pkg::*;
#(
  parameter int unsigned SERVICE_COUNT = ServiceCountDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // service_index [7:0], now_ms [71:8]
  input  wire logic [InDataW-1:0]   s_axis_tdata,
  // req_type [1:0]
  input  wire logic [ReqW-1:0]      s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // stale_mask [7:0], fault_flag [8], received_mask [16:9],
  // heartbeat_taken [17], evaluation_time [81:18], zero [87:82]
  output logic [OutDataW-1:0]       m_axis_tdata,
  input  wire logic                 cfg_we_i,
  input  wire logic [DeadlineW-1:0] cfg_wdata_i
);

  logic [DeadlineW-1:0] deadline_q;
  logic                 head_valid;
  req_t                 head;
  logic                 pop;
  result_t              result;

  // deadline register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadline_q <= DeadlineRst;
    end else if (cfg_we_i) begin
      deadline_q <= cfg_wdata_i;
    end
  end

  mshw_front #(
    .SERVICE_COUNT (SERVICE_COUNT)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .req_type_i      (s_axis_tuser),
    .service_index_i (s_axis_tdata[InSvcLo +: SvcW]),
    .now_ms_i        (s_axis_tdata[InTimeLo +: TimeW]),
    .head_valid_o    (head_valid),
    .head_o          (head),
    .pop_i           (pop)
  );

  mshw_back #(
    .SERVICE_COUNT (SERVICE_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .deadline_i   (deadline_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (result)
  );

  // pack the result item
  always_comb begin
    m_axis_tdata                         = '0;
    m_axis_tdata[OutStaleLo +: MaskW]    = result.stale;
    m_axis_tdata[OutFaultBit]            = result.fault;
    m_axis_tdata[OutRecvLo +: MaskW]     = result.recv;
    m_axis_tdata[OutTakenBit]            = result.taken;
    m_axis_tdata[OutTimeLo +: TimeW]     = result.eval_time;
  end

endmodule

`default_nettype wire

// ===== hdl/mshw_front.sv =====
// request front end: takes items, classifies them and queues them for the back end
// depends on mshw_pkg
`default_nettype none

module mshw_front
  import mshw_pkg::*;
#(
  parameter int unsigned SERVICE_COUNT = ServiceCountDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [ReqW-1:0]  req_type_i,
  input  wire logic [SvcW-1:0]  service_index_i,
  input  wire logic [TimeW-1:0] now_ms_i,
  output logic                  head_valid_o,
  output req_t                  head_o,
  input  wire logic             pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  req_t            queue_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  req_t            entry;
  logic            push;
  logic            pop;

  // classify the incoming request
  always_comb begin
    entry.kind   = req_e'(req_type_i);
    entry.svc_ok = ({1'b0, service_index_i} < (SvcW + 1)'(SERVICE_COUNT));
    entry.svc    = service_index_i;
    entry.now    = now_ms_i;
  end

  assign in_ready_o   = (cnt_q < CntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = queue_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && head_valid_o;

  // queue pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= entry;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mshw_back.sv =====
// request back end: keeps the service stamps and marks, runs init, heartbeat and
// evaluate, and holds the result in an output register; depends on mshw_pkg
`default_nettype none

module mshw_back
  import mshw_pkg::*;
#(
  parameter int unsigned SERVICE_COUNT = ServiceCountDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [DeadlineW-1:0] deadline_i,
  input  wire logic                 head_valid_i,
  input  wire req_t                 head_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output result_t                   out_o
);

  localparam int unsigned IdxW = (SERVICE_COUNT > 1) ? $clog2(SERVICE_COUNT) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_e;

  state_e                   state_q, state_d;
  logic [IdxW-1:0]          cnt_q, cnt_d;
  logic [SERVICE_COUNT-1:0] mask_q, mask_d;
  logic [TimeW-1:0]         eval_now_q, eval_now_d;
  logic [TimeW-1:0]         stamp_q [SERVICE_COUNT];
  logic [TimeW-1:0]         stamp_d [SERVICE_COUNT];
  logic [SERVICE_COUNT-1:0] recv_q, recv_d;
  logic [SERVICE_COUNT-1:0] stale_q, stale_d;
  logic                     fault_q, fault_d;
  logic [TimeW-1:0]         eval_time_q, eval_time_d;
  logic                     out_valid_q, out_valid_d;
  result_t                  out_q, out_d;

  logic                     slot_free;
  logic [IdxW-1:0]          rd_idx;
  logic [TimeW-1:0]         cur_now;
  logic [TimeW-1:0]         last;
  logic [TimeW:0]           diff;
  logic                     behind;
  logic                     beat_ok;
  logic                     stale_cur;
  logic                     load;
  logic                     taken;

  assign slot_free = !out_valid_q || out_ready_i;

  // one shared stamp read and 65-bit subtract, for heartbeat and for evaluate
  assign rd_idx    = (state_q == S_EVAL) ? cnt_q : head_i.svc[IdxW-1:0];
  assign cur_now   = (state_q == S_EVAL) ? eval_now_q : head_i.now;
  assign last      = stamp_q[rd_idx];
  assign diff      = {cur_now[TimeW-1], cur_now} - {last[TimeW-1], last};
  assign behind    = diff[TimeW];
  assign beat_ok   = head_i.svc_ok && !head_i.now[TimeW-1] && !behind;
  assign stale_cur = last[TimeW-1] || behind ||
                     (diff[TimeW-1:0] > {{(TimeW-DeadlineW){1'b0}}, deadline_i});

  // request sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    mask_d      = mask_q;
    eval_now_d  = eval_now_q;
    stamp_d     = stamp_q;
    recv_d      = recv_q;
    stale_d     = stale_q;
    fault_d     = fault_q;
    eval_time_d = eval_time_q;
    pop_o       = 1'b0;
    load        = 1'b0;
    taken       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (head_valid_i && slot_free) begin
          pop_o = 1'b1;
          case (head_i.kind)
            REQ_INIT: begin
              for (int i = 0; i < SERVICE_COUNT; i++) begin
                stamp_d[i] = head_i.now;
              end
              recv_d      = '0;
              stale_d     = '0;
              fault_d     = 1'b0;
              eval_time_d = head_i.now;
              load        = 1'b1;
            end
            REQ_BEAT: begin
              if (beat_ok) begin
                stamp_d[rd_idx] = head_i.now;
                recv_d[rd_idx]  = 1'b1;
                taken           = 1'b1;
              end
              load = 1'b1;
            end
            REQ_EVAL: begin
              eval_now_d = head_i.now;
              cnt_d      = '0;
              mask_d     = '0;
              state_d    = S_EVAL;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_EVAL: begin
        // one service per cycle; the last one holds until the result slot is free
        mask_d[cnt_q] = stale_cur;
        if (cnt_q == IdxW'(SERVICE_COUNT - 1)) begin
          if (slot_free) begin
            stale_d     = mask_d;
            fault_d     = (mask_d != '0);
            eval_time_d = eval_now_q;
            load        = 1'b1;
            state_d     = S_IDLE;
          end
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // result register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (load) begin
      out_d.stale = '0;
      out_d.recv  = '0;
      for (int i = 0; i < SERVICE_COUNT; i++) begin
        out_d.stale[i] = stale_d[i];
        out_d.recv[i]  = recv_d[i];
      end
      out_d.fault     = fault_d;
      out_d.taken     = taken;
      out_d.eval_time = eval_time_d;
      out_valid_d     = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      recv_q      <= '0;
      stale_q     <= '0;
      fault_q     <= 1'b0;
      eval_time_q <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SERVICE_COUNT; i++) begin
        stamp_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      recv_q      <= recv_d;
      stale_q     <= stale_d;
      fault_q     <= fault_d;
      eval_time_q <= eval_time_d;
      out_valid_q <= out_valid_d;
      stamp_q     <= stamp_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mask_q     <= mask_d;
    eval_now_q <= eval_now_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

// ===== hdl/mshw_checker.sv =====
// port-level checks of the heartbeat watchdog result stream, bound to the top level
// depends on mshw_pkg and multi_service_heartbeat_watchdog_core
`default_nettype none

module mshw_checker
  import mshw_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata
);

  logic             out_acc;
  logic [MaskW-1:0] stale;
  logic [MaskW-1:0] recv;
  logic             fault;
  logic             taken;
  logic [TimeW-1:0] eval_time;
  logic [MaskW-1:0] prev_recv_q;
  logic [TimeW-1:0] prev_time_q;

  assign out_acc   = m_axis_tvalid && m_axis_tready;
  assign stale     = m_axis_tdata[OutStaleLo +: MaskW];
  assign recv      = m_axis_tdata[OutRecvLo +: MaskW];
  assign fault     = m_axis_tdata[OutFaultBit];
  assign taken     = m_axis_tdata[OutTakenBit];
  assign eval_time = m_axis_tdata[OutTimeLo +: TimeW];

  // last delivered received mask and evaluation time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_recv_q <= '0;
      prev_time_q <= '0;
    end else if (out_acc) begin
      prev_recv_q <= recv;
      prev_time_q <= eval_time;
    end
  end

  // no result shows while reset is held
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // fault flag follows the stale mask
  a_fault_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (fault == (stale != '0)))
    else $error("fault flag disagrees with stale mask");

  // a taken heartbeat keeps the evaluation time and shows a received bit
  a_beat_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && taken |-> (eval_time == prev_time_q) && (recv != '0))
    else $error("taken heartbeat changed evaluation time or lost received bits");

  // received bits only grow until an init clears them all
  a_recv_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> ((recv & prev_recv_q) == prev_recv_q) || (recv == '0))
    else $error("received mask lost bits without init");

endmodule

bind multi_service_heartbeat_watchdog_core mshw_checker u_mshw_checker (.*);

`default_nettype wire
